### rtl/fbcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbcm_pkg
// Types and constants shared by the FAT block chain manager.
// ----------------------------------------------------------------------------
package fbcm_pkg;

  localparam int unsigned NUM_BLOCKS  = 4096;
  localparam int unsigned NB_AW       = 12;
  localparam int unsigned BLK_W       = 13;
  localparam int unsigned MAX_FILES   = 128;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned SIZE_W      = 25;
  localparam int unsigned OFF_W       = 12;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned N_W         = 6;
  localparam int unsigned BUF_DEPTH   = 64;
  localparam logic [N_W-1:0]    MAX_OUT     = 6'd33;
  localparam logic [BLK_W-1:0]  END_MARK    = 13'd4096;
  localparam logic [LEN_W-1:0]  BLOCK_BYTES = 13'd4096;
  localparam logic [SIZE_W-1:0] PIECE_LIMIT = 25'd131072;

  localparam int unsigned REC_W = SIZE_W + 2 * BLK_W;
  localparam int unsigned CUR_W = 2 * BLK_W;
  localparam int unsigned PCE_W = 3 + 2 * OFF_W + LEN_W;

  typedef enum logic [2:0] {
    FN_FORMAT = 3'd0,
    FN_CREATE = 3'd1,
    FN_APPEND = 3'd2,
    FN_READ   = 3'd3,
    FN_SEEK   = 3'd4,
    FN_TRUNC  = 3'd5,
    FN_DELETE = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SLOT = 3'd1,
    ST_FULL     = 3'd2,
    ST_IN_USE   = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_DISP, S_FMT, S_AP, S_AP_GRAB, S_AP_LINK, S_RD, S_RD_NEXT,
    S_PC, S_PC_NEXT, S_TR_WALK, S_TR_WN, S_TR_CUR, S_TR_CG, S_TR_END, S_WB, S_EMIT
  } state_e;

  typedef struct packed {
    logic [11:0] first_data_block;
    logic [12:0] blocks_in_use;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [BLK_W-1:0]  first;
    logic [BLK_W-1:0]  last;
  } rec_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] idx;
  } cur_t;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] block;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } piece_t;

  function automatic piece_t mk_piece(status_e st, logic [OFF_W-1:0] blk,
                                      logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
    piece_t p;
    p.status = st;
    p.block  = blk;
    p.offset = off;
    p.length = len;
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/fat_block_chain_manager_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fat_block_chain_manager_top
// FAT block chain manager: allocation, read pieces, seek, truncate, delete.
// Single-result items pass load, decode, write back, emit and output register
// before their result strobe; the next item is accepted in the cycle of the
// last strobe, so a new item is taken only once the last one is through.
// Append spends a step per piece plus a grab and, but for a file's first
// block, a link step per new block; read a step per piece plus a next-block
// read per block step, then results stream one per cycle. Seek and truncate
// walk the chain on the next-block table port; format sweeps every entry.
// Reset marks all file slots free and leaves the free list empty until format.
// Results come as strobes the receiver cannot stall.
// ----------------------------------------------------------------------------
module fat_block_chain_manager_top
  import fbcm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        func_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [SIZE_W-1:0] amount_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic [OFF_W-1:0]       block_o,
  output logic [OFF_W-1:0]       offset_o,
  output logic [LEN_W-1:0]       length_o,
  output logic [SIZE_W-1:0]      file_size_o,
  output logic                   last_o
);

  cfg_t cfg;

  fbcm_apb u_apb (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  fbcm_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .start, .busy, .func_i, .slot_i, .amount_i,
    .result_valid_o, .status_o, .block_o, .offset_o, .length_o, .file_size_o, .last_o
  );

endmodule
`default_nettype wire

### rtl/fbcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbcm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fbcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/fbcm_apb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbcm_apb
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module fbcm_apb
  import fbcm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  typedef enum logic {
    REG_FIRST_DATA = 1'b0,
    REG_BLOCKS     = 1'b1
  } reg_e;

  cfg_t cfg_q, cfg_d;
  reg_e idx;

  assign idx    = reg_e'(paddr[2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FIRST_DATA: cfg_d.first_data_block = pwdata[11:0];
        REG_BLOCKS:     cfg_d.blocks_in_use    = pwdata[12:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST_DATA: prdata = {20'd0, cfg_q.first_data_block};
      REG_BLOCKS:     prdata = {19'd0, cfg_q.blocks_in_use};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_data_block <= 12'd4;
      cfg_q.blocks_in_use    <= 13'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### rtl/fbcm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbcm_engine
// Sequencer over the next-block table, file records, cursors and result buffer.
// ----------------------------------------------------------------------------
module fbcm_engine
  import fbcm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cfg_t                   cfg_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        func_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [SIZE_W-1:0] amount_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic [OFF_W-1:0]       block_o,
  output logic [OFF_W-1:0]       offset_o,
  output logic [LEN_W-1:0]       length_o,
  output logic [SIZE_W-1:0]      file_size_o,
  output logic                   last_o
);

  state_e state_q, state_d;
  func_e  func_q, func_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [SIZE_W-1:0]    rem_q, rem_d, size_q, size_d, osize_q, osize_d;
  logic [BLK_W-1:0]     first_q, first_d, last_q, last_d, prev_q, prev_d;
  logic [BLK_W-1:0]     cb_q, cb_d, ci_q, ci_d, cnt_q, cnt_d, fh_q, fh_d;
  logic [N_W-1:0]       n_q, n_d, e_q, e_d;
  logic [MAX_FILES-1:0] valid_q, valid_d;
  logic got_q, got_d, rec_wr_q, rec_wr_d, cur_wr_q, cur_wr_d, zero_q, zero_d;
  logic ovalid_q, ovalid_d, olast_q, olast_d;

  logic             nx_we;
  logic [NB_AW-1:0] nx_waddr, nx_raddr;
  logic [BLK_W-1:0] nx_wdata, nx_rdata;
  logic             rec_we, cur_we, buf_we;
  rec_t             rec_rd, rec_wdata;
  cur_t             cur_rd, cur_wdata;
  piece_t           buf_wdata, buf_rd;

  logic [SIZE_W-1:0] ksum, rclamp;
  logic [BLK_W-1:0]  keep, tail, lim, ap_room, ap_len, rd_room, rd_len, n_eff;
  logic [OFF_W-1:0]  ap_off;

  fbcm_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );
  fbcm_ram #(.WIDTH(REC_W), .DEPTH(MAX_FILES)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(slot_q), .wdata_i(rec_wdata),
    .raddr_i(slot_q), .rdata_o(rec_rd)
  );
  fbcm_ram #(.WIDTH(CUR_W), .DEPTH(MAX_FILES)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(slot_q), .wdata_i(cur_wdata),
    .raddr_i(slot_q), .rdata_o(cur_rd)
  );
  fbcm_ram #(.WIDTH(PCE_W), .DEPTH(BUF_DEPTH)) u_buf (
    .clk_i, .we_i(buf_we), .waddr_i(n_q), .wdata_i(buf_wdata),
    .raddr_i(e_q), .rdata_o(buf_rd)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = ovalid_q;
  assign last_o         = olast_q;
  assign file_size_o    = osize_q;
  assign status_o       = buf_rd.status;
  assign block_o        = buf_rd.block;
  assign offset_o       = buf_rd.offset;
  assign length_o       = buf_rd.length;

  assign rec_wdata = '{size: size_q, first: first_q, last: last_q};
  assign cur_wdata = '{blk: cb_q, idx: ci_q};

  always_comb begin
    ksum    = size_q + SIZE_W'(BLOCK_BYTES - 13'd1);
    keep    = ksum[SIZE_W-1:OFF_W];
    tail    = (size_q[OFF_W-1:0] == '0 && size_q != '0) ? BLOCK_BYTES
                                                        : {1'b0, size_q[OFF_W-1:0]};
    lim     = (cb_q == last_q) ? tail : BLOCK_BYTES;
    ap_off  = size_q[OFF_W-1:0];
    ap_room = BLOCK_BYTES - {1'b0, ap_off};
    ap_len  = (rem_q < {12'd0, ap_room}) ? rem_q[BLK_W-1:0] : ap_room;
    rd_room = lim - ci_q;
    rd_len  = (rem_q < {12'd0, rd_room}) ? rem_q[BLK_W-1:0] : rd_room;
    rclamp  = (rem_q > rec_rd.size) ? rec_rd.size : rem_q;
    n_eff   = (cfg_i.blocks_in_use > END_MARK) ? END_MARK : cfg_i.blocks_in_use;
  end

  always_comb begin
    state_d = state_q; func_d = func_q; slot_d = slot_q; rem_d = rem_q;
    size_d = size_q; osize_d = osize_q; first_d = first_q; last_d = last_q;
    prev_d = prev_q; cb_d = cb_q; ci_d = ci_q; cnt_d = cnt_q; fh_d = fh_q;
    n_d = n_q; e_d = e_q; valid_d = valid_q; got_d = got_q;
    rec_wr_d = rec_wr_q; cur_wr_d = cur_wr_q; zero_d = zero_q;
    ovalid_d = 1'b0; olast_d = 1'b0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = END_MARK; nx_raddr = '0;
    rec_we = 1'b0; cur_we = 1'b0;
    buf_we = 1'b0; buf_wdata = mk_piece(ST_OK, '0, '0, '0);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d   = func_e'(func_i);
          slot_d   = slot_i;
          rem_d    = amount_i;
          n_d      = '0;
          rec_wr_d = 1'b0;
          cur_wr_d = 1'b0;
          zero_d   = 1'b0;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: state_d = S_DISP;
      S_DISP: begin
        size_d  = rec_rd.size;
        first_d = rec_rd.first;
        last_d  = rec_rd.last;
        cb_d    = cur_rd.blk;
        ci_d    = cur_rd.idx;
        unique case (func_q) inside
          FN_FORMAT: begin
            cnt_d   = '0;
            valid_d = '0;
            state_d = S_FMT;
          end
          FN_CREATE: begin
            buf_we  = 1'b1;
            n_d     = n_q + 6'd1;
            state_d = S_WB;
            if (valid_q[slot_q]) begin
              buf_wdata = mk_piece(ST_IN_USE, '0, '0, '0);
            end else begin
              valid_d[slot_q] = 1'b1;
              size_d   = '0;
              first_d  = END_MARK;
              last_d   = END_MARK;
              cb_d     = END_MARK;
              ci_d     = '0;
              rec_wr_d = 1'b1;
              cur_wr_d = 1'b1;
              zero_d   = 1'b1;
            end
          end
          FN_APPEND, FN_READ, FN_SEEK, FN_TRUNC, FN_DELETE: begin
            if (!valid_q[slot_q]) begin
              buf_we    = 1'b1;
              buf_wdata = mk_piece(ST_BAD_SLOT, '0, '0, '0);
              n_d       = n_q + 6'd1;
              zero_d    = 1'b1;
              state_d   = S_WB;
            end else begin
              unique case (func_q) inside
                FN_APPEND, FN_READ: begin
                  if (rem_q > PIECE_LIMIT) begin
                    buf_we    = 1'b1;
                    buf_wdata = mk_piece(ST_TOO_LONG, '0, '0, '0);
                    n_d       = n_q + 6'd1;
                    state_d   = S_WB;
                  end else begin
                    got_d    = 1'b0;
                    cur_wr_d = 1'b1;
                    rec_wr_d = (func_q == FN_APPEND);
                    state_d  = (func_q == FN_APPEND) ? S_AP : S_RD;
                  end
                end
                FN_SEEK: begin
                  cb_d    = rec_rd.first;
                  rem_d   = rclamp;
                  state_d = S_PC;
                end
                FN_TRUNC: begin
                  if (rec_rd.first[BLK_W-1]) begin
                    buf_we  = 1'b1;
                    n_d     = n_q + 6'd1;
                    state_d = S_WB;
                  end else if (rclamp == '0) begin
                    if (!rec_rd.last[BLK_W-1]) begin
                      nx_we    = 1'b1;
                      nx_waddr = rec_rd.last[NB_AW-1:0];
                      nx_wdata = fh_q;
                      fh_d     = rec_rd.first;
                    end
                    size_d   = '0;
                    first_d  = END_MARK;
                    last_d   = END_MARK;
                    cb_d     = END_MARK;
                    ci_d     = '0;
                    rec_wr_d = 1'b1;
                    cur_wr_d = 1'b1;
                    buf_we   = 1'b1;
                    n_d      = n_q + 6'd1;
                    state_d  = S_WB;
                  end else begin
                    size_d  = rclamp;
                    rem_d   = rclamp;
                    prev_d  = rec_rd.first;
                    cnt_d   = 13'd1;
                    state_d = S_TR_WALK;
                  end
                end
                default: begin
                  valid_d[slot_q] = 1'b0;
                  if (!rec_rd.first[BLK_W-1] && !rec_rd.last[BLK_W-1]) begin
                    nx_we    = 1'b1;
                    nx_waddr = rec_rd.last[NB_AW-1:0];
                    nx_wdata = fh_q;
                    fh_d     = rec_rd.first;
                  end
                  buf_we  = 1'b1;
                  n_d     = n_q + 6'd1;
                  zero_d  = 1'b1;
                  state_d = S_WB;
                end
              endcase
            end
          end
          default: begin
            buf_we  = 1'b1;
            n_d     = n_q + 6'd1;
            zero_d  = 1'b1;
            state_d = S_WB;
          end
        endcase
      end
      S_FMT: begin
        nx_we    = 1'b1;
        nx_waddr = cnt_q[NB_AW-1:0];
        nx_wdata = (cnt_q >= {1'b0, cfg_i.first_data_block} && (cnt_q + 13'd1) < n_eff)
                   ? cnt_q + 13'd1 : END_MARK;
        cnt_d    = cnt_q + 13'd1;
        if (cnt_q == END_MARK - 13'd1) begin
          fh_d    = ({1'b0, cfg_i.first_data_block} < n_eff)
                    ? {1'b0, cfg_i.first_data_block} : END_MARK;
          buf_we  = 1'b1;
          n_d     = n_q + 6'd1;
          zero_d  = 1'b1;
          state_d = S_WB;
        end
      end
      S_AP: begin
        if (rem_q == '0 || n_q == MAX_OUT) begin
          if (n_q == '0) begin
            buf_we = 1'b1;
            n_d    = n_q + 6'd1;
          end
          state_d = S_WB;
        end else if (ap_off == '0 && !got_q) begin
          if (fh_q[BLK_W-1]) begin
            buf_we    = 1'b1;
            buf_wdata = mk_piece(ST_FULL, '0, '0, '0);
            n_d       = n_q + 6'd1;
            state_d   = S_WB;
          end else begin
            nx_raddr = fh_q[NB_AW-1:0];
            state_d  = S_AP_GRAB;
          end
        end else begin
          buf_we    = 1'b1;
          buf_wdata = mk_piece(ST_OK, last_q[NB_AW-1:0], ap_off, ap_len);
          n_d       = n_q + 6'd1;
          size_d    = size_q + {12'd0, ap_len};
          rem_d     = rem_q - {12'd0, ap_len};
          got_d     = 1'b0;
        end
      end
      S_AP_GRAB: begin
        fh_d     = nx_rdata;
        nx_we    = 1'b1;
        nx_waddr = fh_q[NB_AW-1:0];
        nx_wdata = END_MARK;
        prev_d   = last_q;
        last_d   = fh_q;
        got_d    = 1'b1;
        if (last_q[BLK_W-1]) begin
          first_d = fh_q;
          cb_d    = fh_q;
          ci_d    = '0;
          state_d = S_AP;
        end else begin
          state_d = S_AP_LINK;
        end
      end
      S_AP_LINK: begin
        nx_we    = 1'b1;
        nx_waddr = prev_q[NB_AW-1:0];
        nx_wdata = last_q;
        state_d  = S_AP;
      end
      S_RD: begin
        if (rem_q == '0 || n_q == MAX_OUT || cb_q[BLK_W-1] ||
            (ci_q >= lim && (cb_q == last_q || ci_q < BLOCK_BYTES))) begin
          if (n_q == '0) begin
            buf_we = 1'b1;
            n_d    = n_q + 6'd1;
          end
          state_d = S_WB;
        end else if (ci_q >= lim) begin
          nx_raddr = cb_q[NB_AW-1:0];
          state_d  = S_RD_NEXT;
        end else begin
          buf_we    = 1'b1;
          buf_wdata = mk_piece(ST_OK, cb_q[NB_AW-1:0], ci_q[OFF_W-1:0], rd_len);
          n_d       = n_q + 6'd1;
          ci_d      = ci_q + rd_len;
          rem_d     = rem_q - {12'd0, rd_len};
        end
      end
      S_RD_NEXT: begin
        cb_d    = nx_rdata;
        ci_d    = '0;
        state_d = S_RD;
      end
      S_PC: begin
        if (cb_q[BLK_W-1] || rem_q <= {12'd0, BLOCK_BYTES}) begin
          ci_d     = cb_q[BLK_W-1] ? '0 : rem_q[BLK_W-1:0];
          cur_wr_d = 1'b1;
          buf_we   = 1'b1;
          n_d      = n_q + 6'd1;
          state_d  = S_WB;
        end else begin
          nx_raddr = cb_q[NB_AW-1:0];
          state_d  = S_PC_NEXT;
        end
      end
      S_PC_NEXT: begin
        cb_d    = nx_rdata;
        rem_d   = rem_q - {12'd0, BLOCK_BYTES};
        state_d = S_PC;
      end
      S_TR_WALK: begin
        nx_raddr = prev_q[NB_AW-1:0];
        state_d  = (cnt_q < keep) ? S_TR_WN : S_TR_CG;
      end
      S_TR_WN: begin
        if (!nx_rdata[BLK_W-1]) begin
          prev_d  = nx_rdata;
          cnt_d   = cnt_q + 13'd1;
          state_d = S_TR_WALK;
        end else begin
          state_d = S_TR_CUR;
        end
      end
      S_TR_CUR: begin
        nx_raddr = prev_q[NB_AW-1:0];
        state_d  = S_TR_CG;
      end
      S_TR_CG: begin
        if (!nx_rdata[BLK_W-1] && !last_q[BLK_W-1]) begin
          nx_we    = 1'b1;
          nx_waddr = last_q[NB_AW-1:0];
          nx_wdata = fh_q;
          fh_d     = nx_rdata;
        end
        state_d = S_TR_END;
      end
      S_TR_END: begin
        nx_we    = 1'b1;
        nx_waddr = prev_q[NB_AW-1:0];
        nx_wdata = END_MARK;
        last_d   = prev_q;
        rec_wr_d = 1'b1;
        cb_d     = first_q;
        state_d  = S_PC;
      end
      S_WB: begin
        rec_we  = rec_wr_q;
        cur_we  = cur_wr_q;
        osize_d = zero_q ? '0 : size_q;
        e_d     = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        ovalid_d = 1'b1;
        olast_d  = (e_q == n_q - 6'd1);
        e_d      = e_q + 6'd1;
        if (e_q == n_q - 6'd1) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      fh_q     <= END_MARK;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      fh_q     <= fh_d;
      ovalid_q <= ovalid_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    slot_q   <= slot_d;
    rem_q    <= rem_d;
    size_q   <= size_d;
    osize_q  <= osize_d;
    first_q  <= first_d;
    last_q   <= last_d;
    prev_q   <= prev_d;
    cb_q     <= cb_d;
    ci_q     <= ci_d;
    cnt_q    <= cnt_d;
    n_q      <= n_d;
    e_q      <= e_d;
    got_q    <= got_d;
    rec_wr_q <= rec_wr_d;
    cur_wr_q <= cur_wr_d;
    zero_q   <= zero_d;
  end

endmodule
`default_nettype wire

### sim/tb_fat_block_chain_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_block_chain_manager_top
// Drives file operations into the FAT block chain manager, tracks the next-block
// table, free list, file records and read cursors alongside it, and compares
// every result strobe field by field against the predicted pieces.
// ----------------------------------------------------------------------------
module tb_fat_block_chain_manager_top;
  import fbcm_pkg::*;

  localparam int unsigned BB        = 4096;
  localparam int unsigned NBLK      = 4096;
  localparam int unsigned PIECES    = 33;
  localparam int unsigned STALL_MAX = 60000;
  localparam logic [2:0]  FN_NONE   = 3'd7;
  localparam logic [2:0]  REG_FIRST = 3'd0;
  localparam logic [2:0]  REG_COUNT = 3'd4;

  typedef struct {
    logic [2:0]        st;
    logic [OFF_W-1:0]  blk;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [SIZE_W-1:0] size;
    logic              last;
  } piece_s;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        func_i = '0;
  logic [SLOT_W-1:0] slot_i = '0;
  logic [SIZE_W-1:0] amount_i = '0;
  logic              result_valid_o;
  logic [2:0]        status_o;
  logic [OFF_W-1:0]  block_o, offset_o;
  logic [LEN_W-1:0]  length_o;
  logic [SIZE_W-1:0] file_size_o;
  logic              last_o;

  fat_block_chain_manager_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // file store shadow
  int unsigned first_blk_cfg = 4, blk_count_cfg = 4096;
  int unsigned next_tbl [NBLK];
  int unsigned free_head = NBLK;
  bit          rec_ok [MAX_FILES];
  int unsigned rec_size [MAX_FILES], rec_first [MAX_FILES], rec_last [MAX_FILES];
  int unsigned cur_blk [MAX_FILES], cur_idx [MAX_FILES];

  piece_s      pending_pieces [$];
  int unsigned errs = 0;
  int unsigned idle_pct = 0;
  int unsigned quiet = 0;

  function automatic bit blk_ok(int unsigned b);
    return b < NBLK;
  endfunction

  function automatic void free_chain(int unsigned first, int unsigned last);
    if (!blk_ok(first) || !blk_ok(last)) return;
    next_tbl[last] = free_head;
    free_head = first;
  endfunction

  function automatic bit take_block(int unsigned s);
    int unsigned b;
    b = free_head;
    if (!blk_ok(b)) return 1'b0;
    free_head = next_tbl[b];
    next_tbl[b] = NBLK;
    if (!blk_ok(rec_last[s])) begin
      rec_first[s] = b;
      cur_blk[s] = b;
      cur_idx[s] = 0;
    end else begin
      next_tbl[rec_last[s]] = b;
    end
    rec_last[s] = b;
    return 1'b1;
  endfunction

  function automatic void set_cursor(int unsigned s, int unsigned off);
    int unsigned b, steps;
    b = rec_first[s];
    steps = 0;
    if (off > rec_size[s]) off = rec_size[s];
    while (blk_ok(b) && off > BB && steps < NBLK) begin
      b = next_tbl[b];
      off -= BB;
      steps++;
    end
    if (!blk_ok(b)) begin
      cur_blk[s] = NBLK;
      cur_idx[s] = 0;
    end else begin
      cur_blk[s] = b;
      cur_idx[s] = off;
    end
  endfunction

  function automatic void shrink_file(int unsigned s, int unsigned size);
    int unsigned keep, prev, nx, i;
    if (size > rec_size[s]) size = rec_size[s];
    if (!blk_ok(rec_first[s])) return;
    if (size == 0) begin
      free_chain(rec_first[s], rec_last[s]);
      rec_first[s] = NBLK;
      rec_last[s] = NBLK;
    end else begin
      keep = (size + BB - 1) / BB;
      prev = rec_first[s];
      for (i = 1; i < keep && i < NBLK; i++) begin
        nx = next_tbl[prev];
        if (!blk_ok(nx)) break;
        prev = nx;
      end
      nx = next_tbl[prev];
      if (blk_ok(nx)) free_chain(nx, rec_last[s]);
      next_tbl[prev] = NBLK;
      rec_last[s] = prev;
    end
    rec_size[s] = size;
    set_cursor(s, size);
  endfunction

  function automatic piece_s mk(logic [2:0] st, int unsigned b, int unsigned o,
                                int unsigned l, int unsigned sz);
    piece_s p;
    p.st = st;
    p.blk = b[OFF_W-1:0];
    p.off = o[OFF_W-1:0];
    p.len = l[LEN_W-1:0];
    p.size = sz[SIZE_W-1:0];
    p.last = 1'b0;
    return p;
  endfunction

  function automatic void predict_pieces(logic [2:0] fn, int unsigned s, int unsigned amt);
    piece_s      q [$];
    int unsigned n_cnt, rem, off, len, cb, ci, tail, lim, i;
    n_cnt = 0;
    rem = amt;
    if (fn == FN_FORMAT) begin
      for (i = 0; i < NBLK; i++)
        next_tbl[i] = (i >= first_blk_cfg && i + 1 < blk_count_cfg) ? i + 1 : NBLK;
      free_head = (first_blk_cfg < blk_count_cfg) ? first_blk_cfg : NBLK;
      foreach (rec_ok[k]) rec_ok[k] = 1'b0;
      q.push_back(mk(ST_OK, 0, 0, 0, 0));
    end else if (fn == FN_NONE) begin
      q.push_back(mk(ST_OK, 0, 0, 0, 0));
    end else if (fn == FN_CREATE) begin
      if (rec_ok[s]) q.push_back(mk(ST_IN_USE, 0, 0, 0, rec_size[s]));
      else begin
        rec_ok[s] = 1'b1;
        rec_size[s] = 0;
        rec_first[s] = NBLK;
        rec_last[s] = NBLK;
        cur_blk[s] = NBLK;
        cur_idx[s] = 0;
        q.push_back(mk(ST_OK, 0, 0, 0, 0));
      end
    end else if (!rec_ok[s]) begin
      q.push_back(mk(ST_BAD_SLOT, 0, 0, 0, 0));
    end else if (fn == FN_APPEND || fn == FN_READ) begin
      if (amt > PIECE_LIMIT) q.push_back(mk(ST_TOO_LONG, 0, 0, 0, rec_size[s]));
      else begin
        if (fn == FN_APPEND) begin
          while (rem > 0 && q.size() < PIECES) begin
            off = rec_size[s] % BB;
            if (off == 0 && !take_block(s)) begin
              q.push_back(mk(ST_FULL, 0, 0, 0, 0));
              break;
            end
            len = BB - off;
            if (len > rem) len = rem;
            q.push_back(mk(ST_OK, rec_last[s], off, len, 0));
            rec_size[s] += len;
            rem -= len;
          end
        end else begin
          cb = cur_blk[s];
          ci = cur_idx[s];
          tail = rec_size[s] % BB;
          if (tail == 0 && rec_size[s] > 0) tail = BB;
          while (rem > 0 && q.size() < PIECES && blk_ok(cb)) begin
            lim = (cb == rec_last[s]) ? tail : BB;
            if (ci >= lim) begin
              if (cb == rec_last[s] || ci < BB) break;
              cb = next_tbl[cb];
              ci = 0;
              continue;
            end
            len = lim - ci;
            if (len > rem) len = rem;
            q.push_back(mk(ST_OK, cb, ci, len, 0));
            ci += len;
            rem -= len;
          end
          cur_blk[s] = cb;
          cur_idx[s] = ci;
        end
        if (q.size() == 0) q.push_back(mk(ST_OK, 0, 0, 0, 0));
        foreach (q[k]) q[k].size = rec_size[s][SIZE_W-1:0];
      end
    end else if (fn == FN_SEEK) begin
      set_cursor(s, amt);
      q.push_back(mk(ST_OK, 0, 0, 0, rec_size[s]));
    end else if (fn == FN_TRUNC) begin
      shrink_file(s, amt);
      q.push_back(mk(ST_OK, 0, 0, 0, rec_size[s]));
    end else begin
      rec_ok[s] = 1'b0;
      if (blk_ok(rec_first[s])) free_chain(rec_first[s], rec_last[s]);
      q.push_back(mk(ST_OK, 0, 0, 0, 0));
    end
    q[q.size()-1].last = 1'b1;
    foreach (q[k]) pending_pieces.push_back(q[k]);
  endfunction

  task automatic send_item(logic [2:0] fn, int unsigned s, int unsigned amt);
    start <= 1'b1;
    func_i <= fn;
    slot_i <= s[SLOT_W-1:0];
    amount_i <= amt[SIZE_W-1:0];
    do @(posedge clk_i); while (busy);
    predict_pieces(fn, s, amt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, int unsigned val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_FIRST) first_blk_cfg = val & 32'hFFF;
    else begin
      blk_count_cfg = val & 32'h1FFF;
      if (blk_count_cfg > NBLK) blk_count_cfg = NBLK;
    end
  endtask

  task automatic set_disk(int unsigned first, int unsigned count);
    drain();
    write_reg(REG_FIRST, first);
    write_reg(REG_COUNT, count);
    send_item(FN_FORMAT, 0, 0);
  endtask

  task automatic test_directed();
    send_item(FN_FORMAT, 0, 0);
    send_item(FN_CREATE, 0, 0);
    send_item(FN_CREATE, 0, 0);
    send_item(FN_CREATE, 127, 0);
    send_item(FN_APPEND, 0, 0);
    send_item(FN_APPEND, 0, 5000);
    send_item(FN_APPEND, 0, 131072);
    send_item(FN_APPEND, 0, 131073);
    send_item(FN_READ, 0, 0);
    send_item(FN_READ, 0, 100000);
    send_item(FN_SEEK, 0, 25'h1FFFFFF);
    send_item(FN_READ, 0, 1);
    send_item(FN_SEEK, 0, 4096);
    send_item(FN_READ, 0, 8192);
    send_item(FN_TRUNC, 0, 4096);
    send_item(FN_TRUNC, 0, 25'h1FFFFFF);
    send_item(FN_TRUNC, 0, 0);
    send_item(FN_APPEND, 127, 8192);
    send_item(FN_READ, 127, 9000);
    send_item(FN_DELETE, 127, 0);
    send_item(FN_READ, 127, 10);
    send_item(FN_SEEK, 5, 0);
    send_item(FN_NONE, 127, 25'h1FFFFFF);
    send_item(FN_DELETE, 0, 0);
    send_item(FN_TRUNC, 1, 10);
  endtask

  task automatic test_disk_limits();
    int unsigned firsts [5] = '{1, 4095, 10, 2, 4};
    int unsigned counts [5] = '{20, 4096, 1, 8191, 12};
    for (int i = 0; i < 5; i++) begin
      set_disk(firsts[i], counts[i]);
      send_item(FN_CREATE, 1, 0);
      send_item(FN_APPEND, 1, 30000);
      send_item(FN_APPEND, 1, 70000);
      send_item(FN_READ, 1, 131072);
      send_item(FN_DELETE, 1, 0);
    end
  endtask

  task automatic test_random(int unsigned pct, int unsigned count);
    int unsigned r, fn_pick, s, amt;
    logic [2:0]  fn;
    idle_pct = 0;
    set_disk($urandom_range(1, 8), $urandom_range(16, 200));
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      fn_pick = $urandom_range(99);
      if (fn_pick < 30) fn = FN_APPEND;
      else if (fn_pick < 55) fn = FN_READ;
      else if (fn_pick < 67) fn = FN_CREATE;
      else if (fn_pick < 77) fn = FN_SEEK;
      else if (fn_pick < 87) fn = FN_TRUNC;
      else if (fn_pick < 96) fn = FN_DELETE;
      else if (fn_pick < 98) fn = FN_FORMAT;
      else fn = FN_NONE;
      s = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(5);
      r = $urandom_range(19);
      if (r == 0) amt = $urandom() & 32'h1FFFFFF;
      else if (r < 4) amt = $urandom_range(0, 131072);
      else if (r < 6) amt = $urandom_range(0, 3) * 4096;
      else amt = $urandom_range(0, 20000);
      send_item(fn, s, amt);
    end
  endtask

  always @(posedge clk_i) begin
    piece_s e;
    if (rst_ni && result_valid_o) begin
      if (pending_pieces.size() == 0) begin
        $error("result with nothing expected");
        errs++;
      end else begin
        e = pending_pieces.pop_front();
        if (status_o !== e.st) begin
          $error("status exp %0d got %0d", e.st, status_o); errs++;
        end
        if (block_o !== e.blk) begin
          $error("block exp %0d got %0d", e.blk, block_o); errs++;
        end
        if (offset_o !== e.off) begin
          $error("offset exp %0d got %0d", e.off, offset_o); errs++;
        end
        if (length_o !== e.len) begin
          $error("length exp %0d got %0d", e.len, length_o); errs++;
        end
        if (file_size_o !== e.size) begin
          $error("file_size exp %0d got %0d", e.size, file_size_o); errs++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errs++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (result_valid_o || (start && !busy) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_disk_limits();
    test_random(38, 67);
    test_random(87, 67);
    test_random(0, 67);
    drain();
    repeat (40) @(posedge clk_i);
    if (errs == 0 && pending_pieces.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/fbcm_pkg.sv
rtl/fbcm_ram.sv
rtl/fbcm_apb.sv
rtl/fbcm_engine.sv
rtl/fat_block_chain_manager_top.sv
sim/tb_fat_block_chain_manager_top.sv
